// ===== src/ipv4_input_validate_classify_top_assert.svh =====
// ============================================================================
// IPv4 input classifier assertion macros
// Shared concurrent assertion forms, clocked by clk and disabled in reset.
// ============================================================================
`ifndef IPV4_INPUT_VALIDATE_CLASSIFY_TOP_ASSERT_SVH
`define IPV4_INPUT_VALIDATE_CLASSIFY_TOP_ASSERT_SVH

// Condition implies property in the same cycle.
`define IVC_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

// Condition implies property in the next cycle.
`define IVC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/ivc_pkg.sv =====
// ============================================================================
// IPv4 input classifier package
// Verdict codes, register indexes, field constants and shared stage types.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ivc_pkg;

    // Verdict codes.
    localparam logic [3:0] V_FORWARD     = 4'd0;
    localparam logic [3:0] V_DNAT        = 4'd1;
    localparam logic [3:0] V_OUTPUT      = 4'd2;
    localparam logic [3:0] V_LOCAL       = 4'd3;
    localparam logic [3:0] V_NO_ROUTE    = 4'd4;
    localparam logic [3:0] V_BAD_CKSUM   = 4'd5;
    localparam logic [3:0] V_BAD_ADDR    = 4'd6;
    localparam logic [3:0] V_BAD_LENGTH  = 4'd7;
    localparam logic [3:0] V_BAD_VERSION = 4'd8;
    localparam logic [3:0] V_OTHER_HOST  = 4'd9;
    localparam logic [3:0] V_DIVERT_BASE = 4'd10;
    localparam logic [3:0] V_DIVERT_LAST = 4'd13;

    // Configuration register indexes.
    localparam logic [2:0] REG_L3_TYPE  = 3'd0;
    localparam logic [2:0] REG_DIVERT_0 = 3'd1;
    localparam logic [2:0] REG_DIVERT_1 = 3'd2;
    localparam logic [2:0] REG_DIVERT_2 = 3'd3;
    localparam logic [2:0] REG_DIVERT_3 = 3'd4;

    // Checksum offload status codes.
    localparam logic [1:0] CK_BAD = 2'd2;

    // Ethernet domain codes.
    localparam logic [2:0] DOM_LOOPBACK  = 3'd0;
    localparam logic [2:0] DOM_BROADCAST = 3'd2;
    localparam logic [2:0] DOM_MULTICAST = 3'd3;
    localparam logic [2:0] DOM_LAST_HOST = 3'd3;

    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [3:0]  IPV4_VERSION  = 4'd4;
    localparam logic [3:0]  MIN_IHL       = 4'd5;
    localparam int          NUM_DIVERT    = 4;

    // Configuration register file.
    typedef struct packed {
        logic [7:0] l3_type;
        logic [NUM_DIVERT-1:0][7:0] divert;
    } cfg_t;

    // Decoded checks for one packet, in priority order.
    typedef struct packed {
        logic       link_short;
        logic       ck_bad_status;
        logic       ck_check;
        logic       dst_zero;
        logic       ver_bad;
        logic       ihl_short;
        logic       tot_short;
        logic       dom_bc_mc;
        logic       dom_other;
        logic       ip_mcast;
        logic       route_miss;
        logic       divert_hit;
        logic [1:0] divert_slot;
        logic       dom_loop;
        logic       local_hit;
        logic       dnat;
        logic       batch;
    } flags_t;

endpackage

`default_nettype wire

// ===== src/ivc_decode.sv =====
// ============================================================================
// IPv4 input classifier header decode
// Evaluates every header and lookup check and forms partial checksum sums.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ivc_decode (
    input  wire logic [63:0]   hdr_a,
    input  wire logic [63:0]   hdr_b,
    input  wire logic [31:0]   dst_address,
    input  wire logic [15:0]   link_length,
    input  wire logic [1:0]    cksum_status,
    input  wire logic [2:0]    eth_domain,
    input  wire logic          route_found,
    input  wire logic [7:0]    hop_type,
    input  wire logic          hop_is_local,
    input  wire logic [31:0]   hop_address,
    input  wire logic          dnat_flow_hit,
    input  wire logic          batch_last,
    input  wire ivc_pkg::cfg_t cfg,
    output ivc_pkg::flags_t    flags,
    output logic [17:0]        sum_a,
    output logic [17:0]        sum_b,
    output logic [16:0]        sum_d
);

    logic [3:0]  version;
    logic [3:0]  ihl;
    logic [15:0] tot_len;
    logic        hit;
    logic [1:0]  slot;

    assign version = hdr_a[63:60];
    assign ihl     = hdr_a[59:56];
    assign tot_len = hdr_a[47:32];

    // Four-word partial sums of the header halves and a two-word sum of the destination.
    assign sum_a = 18'(hdr_a[63:48]) + 18'(hdr_a[47:32])
                 + 18'(hdr_a[31:16]) + 18'(hdr_a[15:0]);
    assign sum_b = 18'(hdr_b[63:48]) + 18'(hdr_b[47:32])
                 + 18'(hdr_b[31:16]) + 18'(hdr_b[15:0]);
    assign sum_d = 17'(dst_address[31:16]) + 17'(dst_address[15:0]);

    // Lowest divert slot holding the hop type wins; type zero never diverts.
    always_comb
    begin
        hit  = 1'b0;
        slot = 2'd0;
        for (int k = ivc_pkg::NUM_DIVERT - 1; k >= 0; k--)
        begin
            if (cfg.divert[k] == hop_type)
            begin
                hit  = 1'b1;
                slot = 2'(k);
            end
        end
        if (hop_type == 8'd0)
        begin
            hit = 1'b0;
        end
    end

    // Individual checks.
    always_comb
    begin
        flags.link_short    = link_length < ivc_pkg::MIN_HDR_BYTES;
        flags.ck_bad_status = cksum_status == ivc_pkg::CK_BAD;
        flags.ck_check      = !cksum_status[1];
        flags.dst_zero      = dst_address == 32'd0;
        flags.ver_bad       = version != ivc_pkg::IPV4_VERSION;
        flags.ihl_short     = ihl < ivc_pkg::MIN_IHL;
        flags.tot_short     = tot_len < {10'd0, ihl, 2'b00};
        flags.dom_bc_mc     = eth_domain == ivc_pkg::DOM_BROADCAST
                           || eth_domain == ivc_pkg::DOM_MULTICAST;
        flags.dom_other     = eth_domain > ivc_pkg::DOM_LAST_HOST;
        flags.ip_mcast      = (&dst_address) || dst_address[31:28] == 4'hE;
        flags.route_miss    = !route_found;
        flags.divert_hit    = hit;
        flags.divert_slot   = slot;
        flags.dom_loop      = eth_domain == ivc_pkg::DOM_LOOPBACK;
        flags.local_hit     = hop_type == cfg.l3_type && hop_is_local
                           && dst_address == hop_address;
        flags.dnat          = dnat_flow_hit;
        flags.batch         = batch_last;
    end

endmodule

`default_nettype wire

// ===== src/ivc_verdict.sv =====
// ============================================================================
// IPv4 input classifier verdict select
// Picks the first failing or matching check in forwarding-rule order.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ivc_verdict (
    input  wire ivc_pkg::flags_t flags,
    input  wire logic            cksum_ok,
    output logic [3:0]           verdict
);

    // Priority chain, first hit decides.
    always_comb
    begin
        if (flags.link_short)
            verdict = ivc_pkg::V_BAD_LENGTH;
        else if (flags.ck_bad_status || (flags.ck_check && !cksum_ok))
            verdict = ivc_pkg::V_BAD_CKSUM;
        else if (flags.dst_zero)
            verdict = ivc_pkg::V_BAD_ADDR;
        else if (flags.ver_bad)
            verdict = ivc_pkg::V_BAD_VERSION;
        else if (flags.ihl_short || flags.tot_short)
            verdict = ivc_pkg::V_BAD_LENGTH;
        else if (flags.dom_bc_mc)
            verdict = ivc_pkg::V_LOCAL;
        else if (flags.dom_other)
            verdict = ivc_pkg::V_OTHER_HOST;
        else if (flags.ip_mcast)
            verdict = ivc_pkg::V_LOCAL;
        else if (flags.route_miss)
            verdict = ivc_pkg::V_NO_ROUTE;
        else if (flags.divert_hit)
            verdict = ivc_pkg::V_DIVERT_BASE + {2'b00, flags.divert_slot};
        else if (flags.dom_loop)
            verdict = ivc_pkg::V_OUTPUT;
        else if (flags.local_hit)
            verdict = flags.dnat ? ivc_pkg::V_DNAT : ivc_pkg::V_LOCAL;
        else
            verdict = ivc_pkg::V_FORWARD;
    end

endmodule

`default_nettype wire

// ===== src/ipv4_input_validate_classify_top.sv =====
// Path: an accepted word passes the decode, checksum fold and verdict registers
// in turn. Throughput: one word per cycle unless the output stalls; each stage
// advances when the one after it is empty or draining, so a stalled output
// does not block a filling pipe.
// Reset: asynchronous, clears all valid bits and restores the registers to
// their defaults (layer-3 type 1, divert slots unused).
// ============================================================================
// IPv4 input validate and classify top level
// Three-stage header validation pipeline with a configuration write port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "ipv4_input_validate_classify_top_assert.svh"

module ipv4_input_validate_classify_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] hdr_a,
    input  wire logic [63:0] hdr_b,
    input  wire logic [31:0] dst_address,
    input  wire logic [15:0] link_length,
    input  wire logic [1:0]  cksum_status,
    input  wire logic [2:0]  eth_domain,
    input  wire logic        route_found,
    input  wire logic [7:0]  hop_type,
    input  wire logic        hop_is_local,
    input  wire logic [31:0] hop_address,
    input  wire logic        dnat_flow_hit,
    input  wire logic        batch_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       verdict,
    output logic             batch_end
);

    ivc_pkg::cfg_t   cfg_reg;
    ivc_pkg::flags_t dec_flags;
    logic [17:0]     dec_sum_a;
    logic [17:0]     dec_sum_b;
    logic [16:0]     dec_sum_d;

    logic            s1_valid_reg;
    ivc_pkg::flags_t s1_flags_reg;
    logic [17:0]     s1_sum_a_reg;
    logic [17:0]     s1_sum_b_reg;
    logic [16:0]     s1_sum_d_reg;

    logic            s2_valid_reg;
    ivc_pkg::flags_t s2_flags_reg;
    logic [16:0]     s2_fold_reg;

    logic            out_valid_reg;
    logic [3:0]      verdict_reg;
    logic            batch_end_reg;

    logic            s1_ready;
    logic            s2_ready;
    logic            s3_ready;
    logic [19:0]     total;
    logic [16:0]     fold_next;
    logic [16:0]     fold2;
    logic            cksum_ok;
    logic [3:0]      verdict_next;

    // Configuration registers, always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.l3_type <= 8'd1;
            cfg_reg.divert  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ivc_pkg::REG_L3_TYPE:  cfg_reg.l3_type   <= cfg_data;
                ivc_pkg::REG_DIVERT_0: cfg_reg.divert[0] <= cfg_data;
                ivc_pkg::REG_DIVERT_1: cfg_reg.divert[1] <= cfg_data;
                ivc_pkg::REG_DIVERT_2: cfg_reg.divert[2] <= cfg_data;
                ivc_pkg::REG_DIVERT_3: cfg_reg.divert[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Backpressure: a stage takes a new word when empty or when it drains.
    assign s3_ready = !out_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: decode checks and partial sums.
    ivc_decode u_decode (
        .hdr_a         (hdr_a),
        .hdr_b         (hdr_b),
        .dst_address   (dst_address),
        .link_length   (link_length),
        .cksum_status  (cksum_status),
        .eth_domain    (eth_domain),
        .route_found   (route_found),
        .hop_type      (hop_type),
        .hop_is_local  (hop_is_local),
        .hop_address   (hop_address),
        .dnat_flow_hit (dnat_flow_hit),
        .batch_last    (batch_last),
        .cfg           (cfg_reg),
        .flags         (dec_flags),
        .sum_a         (dec_sum_a),
        .sum_b         (dec_sum_b),
        .sum_d         (dec_sum_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_flags_reg <= dec_flags;
            s1_sum_a_reg <= dec_sum_a;
            s1_sum_b_reg <= dec_sum_b;
            s1_sum_d_reg <= dec_sum_d;
        end
    end

    // Stage 2: add the partial sums and fold the carries once.
    assign total     = 20'(s1_sum_a_reg) + 20'(s1_sum_b_reg) + 20'(s1_sum_d_reg);
    assign fold_next = 17'(total[15:0]) + 17'(total[19:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_flags_reg <= s1_flags_reg;
            s2_fold_reg  <= fold_next;
        end
    end

    // Stage 3: second fold, checksum test and verdict select.
    assign fold2    = 17'(s2_fold_reg[15:0]) + 17'(s2_fold_reg[16]);
    assign cksum_ok = fold2 == 17'h0FFFF;

    ivc_verdict u_verdict (
        .flags    (s2_flags_reg),
        .cksum_ok (cksum_ok),
        .verdict  (verdict_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s3_ready)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            verdict_reg   <= verdict_next;
            batch_end_reg <= s2_flags_reg.batch;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign batch_end = batch_end_reg;

    // A stalled word in a middle stage must stay put.
    `IVC_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s2_ready, s1_valid_reg)
    `IVC_ASSERT_NEXT(a_s2_hold, s2_valid_reg && !s3_ready, s2_valid_reg)
    // A short link frame always lands as a bad length verdict.
    `IVC_ASSERT_NEXT(a_link_short, s2_valid_reg && s3_ready && s2_flags_reg.link_short,
        out_valid_reg && verdict_reg == ivc_pkg::V_BAD_LENGTH)
    // Verdict codes stay within the defined set.
    `IVC_ASSERT_IMPL(a_verdict_range, out_valid_reg, verdict_reg <= ivc_pkg::V_DIVERT_LAST)

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// IPv4 input validate and classify testbench
// Sends IPv4 header words through the classifier under several register
// settings and predicts each verdict in the bench. Every verdict word is
// checked field by field against the oldest pending prediction. Idle bursts
// occur on both sides, with one long output stall to back up the pipe.
// ============================================================================

module tb_top;

    // Codes that the package does not name.
    localparam logic [1:0]  CKS_NONE       = 2'd0;
    localparam logic [1:0]  CKS_UNKNOWN    = 2'd1;
    localparam logic [1:0]  CKS_GOOD       = 2'd3;
    localparam logic [2:0]  DOM_LOCAL_HOST = 3'd1;
    localparam logic [2:0]  DOM_OTHER      = 3'd4;
    localparam logic [2:0]  DOM_UNDEF_HI   = 3'd7;
    localparam logic [2:0]  REG_UNUSED     = 3'd7;
    localparam logic [3:0]  MCAST_NIBBLE   = 4'hE;
    localparam logic [31:0] BCAST_ADDR     = 32'hFFFF_FFFF;

    localparam int LONG_HOLD    = 64;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_COUNT = 400;

    typedef struct {
        logic [63:0] hdr_a;
        logic [63:0] hdr_b;
        logic [31:0] dst_address;
        logic [15:0] link_length;
        logic [1:0]  cksum_status;
        logic [2:0]  eth_domain;
        logic        route_found;
        logic [7:0]  hop_type;
        logic        hop_is_local;
        logic [31:0] hop_address;
        logic        dnat_flow_hit;
        logic        batch_last;
    } ip_packet_t;

    typedef struct {
        logic [3:0] verdict;
        logic       batch_end;
    } verdict_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] hdr_a = '0;
    logic [63:0] hdr_b = '0;
    logic [31:0] dst_address = '0;
    logic [15:0] link_length = '0;
    logic [1:0]  cksum_status = '0;
    logic [2:0]  eth_domain = '0;
    logic        route_found = 1'b0;
    logic [7:0]  hop_type = '0;
    logic        hop_is_local = 1'b0;
    logic [31:0] hop_address = '0;
    logic        dnat_flow_hit = 1'b0;
    logic        batch_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  verdict;
    logic        batch_end;

    // Packets waiting to be sent and verdicts waiting to arrive.
    ip_packet_t    packet_backlog[$];
    verdict_word_t expected_verdicts[$];

    // Bench copy of the register file.
    logic [7:0] l3_type_shadow = 8'd1;
    logic [7:0] divert_shadow [ivc_pkg::NUM_DIVERT] = '{default: 8'd0};

    int  idle_pct = 0;
    int  send_gap = 0;
    int  hold_cnt = 0;
    bit  long_stall_req = 1'b0;
    int  quiet_cycles = 0;
    int  err_cnt = 0;
    int  packets_sent = 0;
    int  verdicts_checked = 0;
    int  directed_count = 0;
    int  settings_used = 1;
    int  verdict_hist [16] = '{default: 0};

    ipv4_input_validate_classify_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .hdr_a         (hdr_a),
        .hdr_b         (hdr_b),
        .dst_address   (dst_address),
        .link_length   (link_length),
        .cksum_status  (cksum_status),
        .eth_domain    (eth_domain),
        .route_found   (route_found),
        .hop_type      (hop_type),
        .hop_is_local  (hop_is_local),
        .hop_address   (hop_address),
        .dnat_flow_hit (dnat_flow_hit),
        .batch_last    (batch_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .verdict       (verdict),
        .batch_end     (batch_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ones' complement sum of the ten header words, folded to 16 bits.
    function automatic logic [15:0] header_ones_sum(logic [63:0] a, logic [63:0] b,
                                                   logic [31:0] d);
        logic [31:0] acc;
        acc = 32'd0;
        for (int i = 0; i < 4; i++)
        begin
            acc += a[16*i +: 16];
            acc += b[16*i +: 16];
        end
        acc += d[31:16];
        acc += d[15:0];
        acc = acc[15:0] + acc[31:16];
        acc = acc[15:0] + acc[31:16];
        return acc[15:0];
    endfunction

    // Verdict for one packet; the first failing check decides.
    function automatic logic [3:0] classify_packet(ip_packet_t p);
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [15:0] hdr_bytes;
        version   = p.hdr_a[63:60];
        ihl       = p.hdr_a[59:56];
        hdr_bytes = {10'd0, ihl, 2'b00};
        if (p.link_length < ivc_pkg::MIN_HDR_BYTES)
            return ivc_pkg::V_BAD_LENGTH;
        if (p.cksum_status == ivc_pkg::CK_BAD)
            return ivc_pkg::V_BAD_CKSUM;
        if (p.cksum_status != CKS_GOOD &&
            header_ones_sum(p.hdr_a, p.hdr_b, p.dst_address) != 16'hFFFF)
            return ivc_pkg::V_BAD_CKSUM;
        if (p.dst_address == 32'd0)
            return ivc_pkg::V_BAD_ADDR;
        if (version != ivc_pkg::IPV4_VERSION)
            return ivc_pkg::V_BAD_VERSION;
        if (ihl < ivc_pkg::MIN_IHL)
            return ivc_pkg::V_BAD_LENGTH;
        if (p.hdr_a[47:32] < hdr_bytes)
            return ivc_pkg::V_BAD_LENGTH;
        if (p.eth_domain == ivc_pkg::DOM_BROADCAST || p.eth_domain == ivc_pkg::DOM_MULTICAST)
            return ivc_pkg::V_LOCAL;
        if (p.eth_domain > ivc_pkg::DOM_LAST_HOST)
            return ivc_pkg::V_OTHER_HOST;
        if (p.dst_address == BCAST_ADDR || p.dst_address[31:28] == MCAST_NIBBLE)
            return ivc_pkg::V_LOCAL;
        if (!p.route_found)
            return ivc_pkg::V_NO_ROUTE;
        // A zero hop type never matches an unused slot; lowest slot wins.
        if (p.hop_type != 8'd0)
            for (int k = 0; k < ivc_pkg::NUM_DIVERT; k++)
                if (divert_shadow[k] == p.hop_type)
                    return ivc_pkg::V_DIVERT_BASE + 4'(k);
        if (p.eth_domain == ivc_pkg::DOM_LOOPBACK)
            return ivc_pkg::V_OUTPUT;
        if (p.hop_type == l3_type_shadow && p.hop_is_local &&
            p.dst_address == p.hop_address)
            return p.dnat_flow_hit ? ivc_pkg::V_DNAT : ivc_pkg::V_LOCAL;
        return ivc_pkg::V_FORWARD;
    endfunction

    // Fill in the header checksum so that the header sums to all ones.
    function automatic ip_packet_t with_checksum(ip_packet_t p);
        p.hdr_b[47:32] = 16'd0;
        p.hdr_b[47:32] = ~header_ones_sum(p.hdr_a, p.hdr_b, p.dst_address);
        return p;
    endfunction

    function automatic ip_packet_t flip_header_bit(ip_packet_t p);
        int bit_idx;
        bit_idx = $urandom_range(0, 159);
        if (bit_idx < 64)
            p.hdr_a[bit_idx] = ~p.hdr_a[bit_idx];
        else if (bit_idx < 128)
            p.hdr_b[bit_idx - 64] = ~p.hdr_b[bit_idx - 64];
        else
            p.dst_address[bit_idx - 128] = ~p.dst_address[bit_idx - 128];
        return p;
    endfunction

    // A valid unicast packet, forwarded unless a divert slot holds the layer-3 type.
    function automatic ip_packet_t clean_packet();
        ip_packet_t p;
        logic [3:0] ihl;
        ihl = 4'($urandom_range(ivc_pkg::MIN_IHL, 15));
        p.hdr_a = {$urandom, $urandom};
        p.hdr_a[63:56] = {ivc_pkg::IPV4_VERSION, ihl};
        p.hdr_a[47:32] = 16'($urandom_range({ihl, 2'b00}, 65535));
        p.hdr_b = {$urandom, $urandom};
        p.dst_address = $urandom;
        if (p.dst_address[31:28] >= MCAST_NIBBLE)
            p.dst_address[31] = 1'b0;
        if (p.dst_address == 32'd0)
            p.dst_address = 32'd1;
        p.link_length   = 16'($urandom_range(ivc_pkg::MIN_HDR_BYTES, 65535));
        p.cksum_status  = CKS_NONE;
        p.eth_domain    = DOM_LOCAL_HOST;
        p.route_found   = 1'b1;
        p.hop_type      = l3_type_shadow;
        p.hop_is_local  = 1'b0;
        p.hop_address   = $urandom;
        p.dnat_flow_hit = 1'b0;
        p.batch_last    = 1'($urandom);
        return with_checksum(p);
    endfunction

    // Mostly well-formed traffic, with each check broken now and then.
    function automatic ip_packet_t random_packet();
        ip_packet_t p;
        int pick;
        bit noise;
        p = clean_packet();
        noise = 1'b0;
        pick = $urandom_range(0, 9);
        p.cksum_status = (pick < 4) ? CKS_NONE : (pick < 7) ? CKS_UNKNOWN : CKS_GOOD;
        pick = $urandom_range(0, 9);
        p.eth_domain = (pick < 7) ? DOM_LOCAL_HOST :
                       (pick < 9) ? ivc_pkg::DOM_LOOPBACK : 3'($urandom_range(0, 7));
        // Aim the hop type at the programmed codes to reach divert and local.
        pick = $urandom_range(0, 7);
        if (pick >= 1 && pick <= ivc_pkg::NUM_DIVERT)
            p.hop_type = divert_shadow[pick - 1];
        else if (pick == 5)
            p.hop_type = 8'd0;
        else if (pick == 6)
            p.hop_type = 8'($urandom);
        p.hop_is_local = 1'($urandom);
        if ($urandom_range(0, 1))
            p.hop_address = p.dst_address;
        p.dnat_flow_hit = 1'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 70)
            ;
        else if (pick < 73)
            p.link_length = 16'($urandom_range(0, ivc_pkg::MIN_HDR_BYTES - 1));
        else if (pick < 76)
            p.cksum_status = ivc_pkg::CK_BAD;
        else if (pick < 79)
            p.dst_address = 32'd0;
        else if (pick < 82)
            p.hdr_a[63:60] = ivc_pkg::IPV4_VERSION ^ 4'($urandom_range(1, 15));
        else if (pick < 85)
            p.hdr_a[59:56] = 4'($urandom_range(0, ivc_pkg::MIN_IHL - 1));
        else if (pick < 88)
            p.hdr_a[47:32] = 16'($urandom_range(0, {p.hdr_a[59:56], 2'b00} - 1));
        else if (pick < 91)
            p.dst_address = $urandom_range(0, 1) ? BCAST_ADDR : {MCAST_NIBBLE, 28'($urandom)};
        else if (pick < 94)
            p.route_found = 1'b0;
        else if (pick < 97)
        begin
            noise           = 1'b1;
            p.hdr_a         = {$urandom, $urandom};
            p.hdr_b         = {$urandom, $urandom};
            p.dst_address   = $urandom;
            p.link_length   = 16'($urandom);
            p.cksum_status  = 2'($urandom);
            p.eth_domain    = 3'($urandom);
            p.route_found   = 1'($urandom);
            p.hop_type      = 8'($urandom);
            p.hop_address   = $urandom;
        end
        else
            p.eth_domain = 3'($urandom_range(ivc_pkg::DOM_BROADCAST, DOM_UNDEF_HI));

        if (!noise)
            p = with_checksum(p);
        if ($urandom_range(0, 19) == 0)
            p = flip_header_bit(p);
        return p;
    endfunction

    // Sender: presents one packet per word, with random idle bursts.
    always @(posedge clk)
    begin
        ip_packet_t next_pkt;
        if (rst_n && (!in_valid || in_ready))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (packet_backlog.size() != 0)
            begin
                if ($urandom_range(1, 100) <= idle_pct)
                begin
                    send_gap = $urandom_range(0, 7);
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_pkt = packet_backlog.pop_front();
                    hdr_a         <= next_pkt.hdr_a;
                    hdr_b         <= next_pkt.hdr_b;
                    dst_address   <= next_pkt.dst_address;
                    link_length   <= next_pkt.link_length;
                    cksum_status  <= next_pkt.cksum_status;
                    eth_domain    <= next_pkt.eth_domain;
                    route_found   <= next_pkt.route_found;
                    hop_type      <= next_pkt.hop_type;
                    hop_is_local  <= next_pkt.hop_is_local;
                    hop_address   <= next_pkt.hop_address;
                    dnat_flow_hit <= next_pkt.dnat_flow_hit;
                    batch_last    <= next_pkt.batch_last;
                    in_valid      <= 1'b1;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, plus one long hold when requested.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                hold_cnt = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(1, 100) <= idle_pct)
            begin
                hold_cnt = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Checker: compares verdict words, predicts accepted packets, tracks
    // register writes and watches for a hang.
    always @(posedge clk)
    begin
        verdict_word_t want;
        ip_packet_t    seen;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                verdicts_checked++;
                if (expected_verdicts.size() == 0)
                begin
                    $error("verdict word %0d arrived with no packet pending", verdict);
                    err_cnt++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict !== want.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d", want.verdict, verdict);
                        err_cnt++;
                    end
                    if (batch_end !== want.batch_end)
                    begin
                        $error("batch_end: expected %0d, got %0d", want.batch_end, batch_end);
                        err_cnt++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                seen.hdr_a         = hdr_a;
                seen.hdr_b         = hdr_b;
                seen.dst_address   = dst_address;
                seen.link_length   = link_length;
                seen.cksum_status  = cksum_status;
                seen.eth_domain    = eth_domain;
                seen.route_found   = route_found;
                seen.hop_type      = hop_type;
                seen.hop_is_local  = hop_is_local;
                seen.hop_address   = hop_address;
                seen.dnat_flow_hit = dnat_flow_hit;
                seen.batch_last    = batch_last;
                want.verdict   = classify_packet(seen);
                want.batch_end = batch_last;
                expected_verdicts.push_back(want);
                verdict_hist[want.verdict]++;
                packets_sent++;
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ivc_pkg::REG_L3_TYPE)
                    l3_type_shadow = cfg_data;
                else if (cfg_index >= ivc_pkg::REG_DIVERT_0 &&
                         cfg_index <= ivc_pkg::REG_DIVERT_3)
                    divert_shadow[cfg_index - ivc_pkg::REG_DIVERT_0] = cfg_data;
            end

            if ((out_valid && out_ready) || (in_valid && in_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d verdicts outstanding",
                         quiet_cycles, expected_verdicts.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_registers(input logic [7:0] l3_val,
                                     input logic [7:0] d0, input logic [7:0] d1,
                                     input logic [7:0] d2, input logic [7:0] d3);
        write_reg(ivc_pkg::REG_L3_TYPE, l3_val);
        write_reg(ivc_pkg::REG_DIVERT_0, d0);
        write_reg(ivc_pkg::REG_DIVERT_1, d1);
        write_reg(ivc_pkg::REG_DIVERT_2, d2);
        write_reg(ivc_pkg::REG_DIVERT_3, d3);
        settings_used++;
    endtask

    // Wait until every packet is sent and every verdict has come back.
    task automatic wait_drained();
        while (packet_backlog.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Test sequence: one phase per register setting.
    initial
    begin
        ip_packet_t p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset register values: one pass over every check in order.
        idle_pct = 20;
        p = clean_packet(); p.link_length = 16'd0; packet_backlog.push_back(p);
        p = clean_packet(); p.link_length = ivc_pkg::MIN_HDR_BYTES - 1;
        packet_backlog.push_back(p);
        p = clean_packet();
        p.link_length = 16'hFFFF;
        p.hdr_a[59:56] = 4'hF;
        p.hdr_a[47:32] = 16'd60;
        p = with_checksum(p);
        packet_backlog.push_back(p);
        p.hdr_a[47:32] = 16'd59; p = with_checksum(p); packet_backlog.push_back(p);
        p = clean_packet(); p.cksum_status = ivc_pkg::CK_BAD; packet_backlog.push_back(p);
        p = clean_packet(); p.hdr_b[32] = ~p.hdr_b[32]; packet_backlog.push_back(p);
        p.cksum_status = CKS_UNKNOWN; packet_backlog.push_back(p);
        p.cksum_status = CKS_GOOD; packet_backlog.push_back(p);
        p = clean_packet(); p.dst_address = 32'd0; p = with_checksum(p);
        packet_backlog.push_back(p);
        p = clean_packet(); p.hdr_a[63:60] = 4'd0; p = with_checksum(p);
        packet_backlog.push_back(p);
        p = clean_packet(); p.hdr_a[59:56] = ivc_pkg::MIN_IHL - 1; p = with_checksum(p);
        packet_backlog.push_back(p);
        p = clean_packet(); p.eth_domain = ivc_pkg::DOM_BROADCAST; packet_backlog.push_back(p);
        p.eth_domain = ivc_pkg::DOM_MULTICAST; packet_backlog.push_back(p);
        p.eth_domain = DOM_OTHER; packet_backlog.push_back(p);
        p.eth_domain = DOM_UNDEF_HI; packet_backlog.push_back(p);
        p = clean_packet(); p.dst_address = BCAST_ADDR; p = with_checksum(p);
        packet_backlog.push_back(p);
        p.dst_address = {MCAST_NIBBLE, 28'd0}; p = with_checksum(p);
        packet_backlog.push_back(p);
        p = clean_packet(); p.route_found = 1'b0; packet_backlog.push_back(p);
        p = clean_packet(); p.eth_domain = ivc_pkg::DOM_LOOPBACK; packet_backlog.push_back(p);
        // Zero hop type against unused divert slots still forwards.
        p = clean_packet(); p.hop_type = 8'd0; packet_backlog.push_back(p);
        p = clean_packet(); p.hop_is_local = 1'b1; p.hop_address = p.dst_address;
        packet_backlog.push_back(p);
        p.dnat_flow_hit = 1'b1; packet_backlog.push_back(p);
        directed_count = packet_backlog.size();
        repeat (RANDOM_COUNT) packet_backlog.push_back(random_packet());
        wait_drained();

        // Slot 0 shadows the layer-3 type, slots 1 and 2 share a code.
        idle_pct = 30;
        program_registers(8'h01, 8'h01, 8'h05, 8'h05, 8'hFF);
        p = clean_packet(); p.hop_is_local = 1'b1; p.hop_address = p.dst_address;
        packet_backlog.push_back(p);
        p = clean_packet(); p.hop_type = 8'h05; packet_backlog.push_back(p);
        p = clean_packet(); p.hop_type = 8'hFF; p.eth_domain = ivc_pkg::DOM_LOOPBACK;
        packet_backlog.push_back(p);
        directed_count += 3;
        repeat (RANDOM_COUNT) packet_backlog.push_back(random_packet());
        wait_drained();

        // Top layer-3 code, no diverts; hold the output long to back up the pipe.
        idle_pct = 0;
        program_registers(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (RANDOM_COUNT) packet_backlog.push_back(random_packet());
        long_stall_req = 1'b1;
        wait_drained();

        // Layer-3 code zero; a write to an unmapped index changes nothing.
        idle_pct = 15;
        program_registers(8'h00, 8'h00, 8'h80, 8'h00, 8'h7F);
        write_reg(REG_UNUSED, 8'hA5);
        repeat (RANDOM_COUNT) packet_backlog.push_back(random_packet());
        wait_drained();

        // Random codes, no idling for the rest of the run.
        idle_pct = 0;
        program_registers(8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
        repeat (RANDOM_COUNT) packet_backlog.push_back(random_packet());
        wait_drained();

        $display("Sent %0d packets (%0d directed) under %0d register settings, %0d verdicts",
                 packets_sent, directed_count, settings_used, verdicts_checked);
        $display({"Verdict mix fwd/dnat/out/local/noroute %0d/%0d/%0d/%0d/%0d, ",
                  "cksum/addr/len/ver/other %0d/%0d/%0d/%0d/%0d, divert %0d/%0d/%0d/%0d"},
                 verdict_hist[ivc_pkg::V_FORWARD], verdict_hist[ivc_pkg::V_DNAT],
                 verdict_hist[ivc_pkg::V_OUTPUT], verdict_hist[ivc_pkg::V_LOCAL],
                 verdict_hist[ivc_pkg::V_NO_ROUTE], verdict_hist[ivc_pkg::V_BAD_CKSUM],
                 verdict_hist[ivc_pkg::V_BAD_ADDR], verdict_hist[ivc_pkg::V_BAD_LENGTH],
                 verdict_hist[ivc_pkg::V_BAD_VERSION], verdict_hist[ivc_pkg::V_OTHER_HOST],
                 verdict_hist[ivc_pkg::V_DIVERT_BASE],
                 verdict_hist[ivc_pkg::V_DIVERT_BASE + 4'd1],
                 verdict_hist[ivc_pkg::V_DIVERT_BASE + 4'd2],
                 verdict_hist[ivc_pkg::V_DIVERT_BASE + 4'd3]);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
